[rtl/p2ptrs_pkg.sv]
// Package: shared types and constants of the point-to-point task round scheduler.
package p2ptrs_pkg;

    localparam int MAX_RANKS    = 64;
    localparam int QUEUE_DEPTH  = 8;
    localparam int MAX_TASKS    = 512;
    localparam int TASK_ID_BITS = 16;

    localparam int RANK_W = $clog2(MAX_RANKS);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int QSEL_W = RANK_W + 1;
    localparam int FILL_W = SLOT_W + 1;
    localparam int CNT_W  = RANK_W + 1;
    localparam int PEND_W = $clog2(MAX_TASKS) + 1;
    localparam int BASE_W = 2 * CNT_W - 1;

    localparam logic [2:0] CFG_RANK_COUNT = 3'd0;
    localparam logic [2:0] CFG_GROUP_SIZE = 3'd1;
    localparam logic [2:0] CFG_N_GROUPS   = 3'd2;
    localparam logic [2:0] CFG_MY_GROUP   = 3'd3;
    localparam logic [2:0] CFG_MY_LOCAL   = 3'd4;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic                    operation;
        logic [5:0]              peer_rank;
        logic                    is_send;
        logic [TASK_ID_BITS-1:0] task_id;
    } req_word_t;

    typedef struct packed {
        status_t                 status;
        logic [TASK_ID_BITS-1:0] out_task;
        logic                    out_is_send;
        logic                    last;
    } rsp_word_t;

    typedef struct packed {
        logic              send_far;
        logic [RANK_W-1:0] send_peer;
        logic              recv_far;
        logic [RANK_W-1:0] recv_peer;
    } tbl_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } qmeta_t;

endpackage

[rtl/p2p_task_round_scheduler_core.sv]
// Top level: point-to-point task round scheduler with table, queue and task memories.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------------
//  req     | in        | req_valid/req_stall| req_word_t: operation, peer, kind, task
//  rsp     | out       | rsp_valid/rsp_stall| rsp_word_t: status, task, kind, last
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (7 bits)
//
//  One word is worked at a time. An append reads the queue state, writes it
//  back and gives the result. A take visits round table positions in turn
//  (table read, queue state read, task read), at most twice the round count
//  of positions; the registered memory reads set these steps. The first word
//  after reset first builds the round table by modulo reduction, group
//  stepping and one table write per round.
//  Reset clears control state and the per-queue valid bits; no clearing pass.
//  A finished result sits in the output register while the next word is taken.
module p2p_task_round_scheduler_core
    import p2ptrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_word_t   rsp_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int NQUEUES = 2 * MAX_RANKS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_INIT   = 11'b000_0000_0010,
        S_STEP   = 11'b000_0000_0100,
        S_ROUND  = 11'b000_0000_1000,
        S_DISP   = 11'b000_0001_0000,
        S_A_WR   = 11'b000_0010_0000,
        S_T_TBL  = 11'b000_0100_0000,
        S_T_META = 11'b000_1000_0000,
        S_T_CHK  = 11'b001_0000_0000,
        S_T_OUT  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    // control and configuration
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    rank_count_reg, rank_count_next;
    logic [CNT_W-1:0]    group_size_reg, group_size_next;
    logic [CNT_W-1:0]    n_groups_reg, n_groups_next;
    logic [RANK_W-1:0]   my_group_reg, my_group_next;
    logic [RANK_W-1:0]   my_local_reg, my_local_next;
    req_word_t           item_reg, item_next;
    logic                table_ready_reg, table_ready_next;
    logic [CNT_W-1:0]    round_total_reg, round_total_next;

    // table build
    logic [CNT_W-1:0]    gs_reg, gs_next, ng_reg, ng_next;
    logic [CNT_W-1:0]    mg_reg, mg_next, ml_reg, ml_next;
    logic [CNT_W-1:0]    p2_reg, p2_next, step_reg, step_next;
    logic [CNT_W-1:0]    gdelta_reg, gdelta_next, rnd_reg, rnd_next, d_reg, d_next;
    logic [BASE_W-1:0]   sbase_reg, sbase_next, rbase_reg, rbase_next;

    // task walk
    logic [PEND_W-1:0]   pending_reg, pending_next;
    logic [RANK_W-1:0]   cur_round_reg, cur_round_next;
    logic                cur_phase_reg, cur_phase_next;
    logic [RANK_W-1:0]   r_reg, r_next;
    logic                ph_reg, ph_next;
    logic [CNT_W:0]      n_reg, n_next;
    logic [QSEL_W-1:0]   q_reg, q_next;
    rsp_word_t           res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;
    logic [NQUEUES-1:0]  qvld_reg, qvld_next;

    // memories
    logic [$bits(tbl_entry_t)-1:0]  tbl_mem [MAX_RANKS];
    tbl_entry_t                     tbl_rd;
    logic                           tbl_we;
    tbl_entry_t                     tbl_wdata;

    logic [$bits(qmeta_t)-1:0]      meta_mem [NQUEUES];
    qmeta_t                         meta_rd;
    logic                           meta_vld_rd;
    logic [QSEL_W-1:0]              meta_raddr;
    logic                           meta_we;
    logic [QSEL_W-1:0]              meta_waddr;
    qmeta_t                         meta_wdata;

    logic [TASK_ID_BITS-1:0]        store_mem [NQUEUES * QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0]        store_rd;
    logic [QSEL_W+SLOT_W-1:0]       store_raddr;
    logic                           store_we;
    logic [QSEL_W+SLOT_W-1:0]       store_waddr;

    // working values
    logic [SLOT_W-1:0]   q_head;
    logic [FILL_W-1:0]   q_fill;
    logic [CNT_W:0]      sum_s, sum_r, sum_x, sum_y;
    logic [CNT_W-1:0]    sg, rg, xo, yo, step_inc;
    logic [BASE_W-1:0]   sv, rv;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    r_inc;
    logic [RANK_W-1:0]   r_adv;
    logic                ph_adv;
    logic                last_pos;
    logic                who_far;
    logic [RANK_W-1:0]   who;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] c;
        if (v == '0)
            c = CNT_W'(1);
        else if (v > CNT_W'(MAX_RANKS))
            c = CNT_W'(MAX_RANKS);
        else
            c = v;
        return c;
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // queue state of an entry never written reads as empty
    assign q_head = meta_vld_rd ? meta_rd.head : '0;
    assign q_fill = meta_vld_rd ? meta_rd.fill : '0;

    // group and local offsets, each one compare and subtract
    assign sum_s = {1'b0, mg_reg} + {1'b0, gdelta_reg};
    assign sg    = (sum_s >= {1'b0, ng_reg}) ? CNT_W'(sum_s - {1'b0, ng_reg}) : CNT_W'(sum_s);
    assign sum_r = {1'b0, mg_reg} + {1'b0, ng_reg} - {1'b0, gdelta_reg};
    assign rg    = (sum_r >= {1'b0, ng_reg}) ? CNT_W'(sum_r - {1'b0, ng_reg}) : CNT_W'(sum_r);
    assign sum_x = {1'b0, ml_reg} + {1'b0, d_reg};
    assign xo    = (sum_x >= {1'b0, gs_reg}) ? CNT_W'(sum_x - {1'b0, gs_reg}) : CNT_W'(sum_x);
    assign sum_y = {1'b0, ml_reg} + {1'b0, gs_reg} - {1'b0, d_reg};
    assign yo    = (sum_y >= {1'b0, gs_reg}) ? CNT_W'(sum_y - {1'b0, gs_reg}) : CNT_W'(sum_y);
    assign sv    = sbase_reg + BASE_W'(xo);
    assign rv    = rbase_reg + BASE_W'(yo);
    assign step_inc = step_reg + CNT_W'(1);

    assign lim = (rank_count_reg < CNT_W'(MAX_RANKS)) ? rank_count_reg : CNT_W'(MAX_RANKS);

    // next walk position: send side then receive side of each round
    assign r_inc    = {1'b0, r_reg} + CNT_W'(1);
    assign ph_adv   = ~ph_reg;
    assign r_adv    = ph_reg ? ((r_inc >= round_total_reg) ? '0 : r_inc[RANK_W-1:0]) : r_reg;
    assign last_pos = ((n_reg + (CNT_W+1)'(1)) == {round_total_reg, 1'b0});
    assign who_far  = ph_reg ? tbl_rd.recv_far : tbl_rd.send_far;
    assign who      = ph_reg ? tbl_rd.recv_peer : tbl_rd.send_peer;

    assign meta_raddr  = (state_reg == S_T_META) ? {who, ~ph_reg}
                                                 : {item_reg.peer_rank, item_reg.is_send};
    assign store_raddr = {q_reg, q_head};

    always_comb
    begin
        state_next       = state_reg;
        rank_count_next  = rank_count_reg;
        group_size_next  = group_size_reg;
        n_groups_next    = n_groups_reg;
        my_group_next    = my_group_reg;
        my_local_next    = my_local_reg;
        item_next        = item_reg;
        table_ready_next = table_ready_reg;
        round_total_next = round_total_reg;
        gs_next          = gs_reg;
        ng_next          = ng_reg;
        mg_next          = mg_reg;
        ml_next          = ml_reg;
        p2_next          = p2_reg;
        step_next        = step_reg;
        gdelta_next      = gdelta_reg;
        rnd_next         = rnd_reg;
        d_next           = d_reg;
        sbase_next       = sbase_reg;
        rbase_next       = rbase_reg;
        pending_next     = pending_reg;
        cur_round_next   = cur_round_reg;
        cur_phase_next   = cur_phase_reg;
        r_next           = r_reg;
        ph_next          = ph_reg;
        n_next           = n_reg;
        q_next           = q_reg;
        res_next         = res_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_word_next    = rsp_word_reg;
        qvld_next        = qvld_reg;
        tbl_we           = 1'b0;
        tbl_wdata        = '{send_far: |sv[BASE_W-1:RANK_W], send_peer: sv[RANK_W-1:0],
                             recv_far: |rv[BASE_W-1:RANK_W], recv_peer: rv[RANK_W-1:0]};
        meta_we          = 1'b0;
        meta_waddr       = q_reg;
        meta_wdata       = '{head: q_head, fill: q_fill};
        store_we         = 1'b0;
        store_waddr      = {q_reg, SLOT_W'(q_head + q_fill[SLOT_W-1:0])};

        // drop the result once the consumer takes it
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RANK_COUNT: rank_count_next = cfg_data;
                CFG_GROUP_SIZE: group_size_next = cfg_data;
                CFG_N_GROUPS:   n_groups_next   = cfg_data;
                CFG_MY_GROUP:   my_group_next   = cfg_data[RANK_W-1:0];
                CFG_MY_LOCAL:   my_local_next   = cfg_data[RANK_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req_word;
                    gs_next   = clamp_cnt(group_size_reg);
                    ng_next   = clamp_cnt(n_groups_reg);
                    mg_next   = CNT_W'(my_group_reg);
                    ml_next   = CNT_W'(my_local_reg);
                    p2_next   = CNT_W'(1);
                    state_next = table_ready_reg ? S_DISP : S_INIT;
                end
            end

            // reduce group and local offsets, find the power of two
            S_INIT:
            begin
                if (mg_reg >= ng_reg)
                    mg_next = mg_reg - ng_reg;
                if (ml_reg >= gs_reg)
                    ml_next = ml_reg - gs_reg;
                if (p2_reg < ng_reg)
                    p2_next = {p2_reg[CNT_W-2:0], 1'b0};
                if (mg_reg < ng_reg && ml_reg < gs_reg && p2_reg >= ng_reg)
                begin
                    step_next   = '0;
                    gdelta_next = '0;
                    rnd_next    = '0;
                    state_next  = S_STEP;
                end
            end

            S_STEP:
            begin
                if (gdelta_reg < ng_reg)
                begin
                    sbase_next = BASE_W'(sg) * BASE_W'(gs_reg);
                    rbase_next = BASE_W'(rg) * BASE_W'(gs_reg);
                    d_next     = '0;
                    state_next = S_ROUND;
                end
                else if (step_inc == p2_reg)
                begin
                    table_ready_next = 1'b1;
                    round_total_next = rnd_reg;
                    state_next       = S_DISP;
                end
                else
                begin
                    step_next   = step_inc;
                    gdelta_next = CNT_W'(gdelta_reg + step_inc) & (p2_reg - CNT_W'(1));
                end
            end

            S_ROUND:
            begin
                if (d_reg < gs_reg && rnd_reg < CNT_W'(MAX_RANKS))
                begin
                    tbl_we   = 1'b1;
                    rnd_next = rnd_reg + CNT_W'(1);
                    d_next   = d_reg + CNT_W'(1);
                end
                else if (step_inc == p2_reg)
                begin
                    table_ready_next = 1'b1;
                    round_total_next = rnd_reg;
                    state_next       = S_DISP;
                end
                else
                begin
                    step_next   = step_inc;
                    gdelta_next = CNT_W'(gdelta_reg + step_inc) & (p2_reg - CNT_W'(1));
                    state_next  = S_STEP;
                end
            end

            S_DISP:
            begin
                res_next = '{status: ST_EMPTY, out_task: '0, out_is_send: 1'b0, last: 1'b0};
                if (item_reg.operation == OP_APPEND)
                begin
                    q_next = {item_reg.peer_rank, item_reg.is_send};
                    if (CNT_W'(item_reg.peer_rank) >= lim)
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_A_WR;
                end
                else if (pending_reg == '0 || round_total_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    if (CNT_W'(cur_round_reg) >= round_total_reg)
                    begin
                        r_next  = '0;
                        ph_next = 1'b0;
                    end
                    else
                    begin
                        r_next  = cur_round_reg;
                        ph_next = cur_phase_reg;
                    end
                    n_next     = '0;
                    state_next = S_T_TBL;
                end
            end

            S_A_WR:
            begin
                if (q_fill >= FILL_W'(QUEUE_DEPTH) || pending_reg >= PEND_W'(MAX_TASKS))
                    res_next.status = ST_FULL;
                else
                begin
                    res_next.status = ST_OK;
                    store_we        = 1'b1;
                    meta_we         = 1'b1;
                    meta_wdata.fill = q_fill + FILL_W'(1);
                    qvld_next[q_reg] = 1'b1;
                    pending_next    = pending_reg + PEND_W'(1);
                end
                state_next = S_DONE;
            end

            S_T_TBL:
                state_next = S_T_META;

            S_T_META:
            begin
                q_next = {who, ~ph_reg};
                if (!who_far)
                    state_next = S_T_CHK;
                else if (last_pos)
                    state_next = S_DONE;
                else
                begin
                    r_next     = r_adv;
                    ph_next    = ph_adv;
                    n_next     = n_reg + (CNT_W+1)'(1);
                    state_next = S_T_TBL;
                end
            end

            S_T_CHK:
            begin
                if (q_fill != '0)
                begin
                    // pop: advance head, drop one from the fill
                    meta_we          = 1'b1;
                    meta_wdata.head  = q_head + SLOT_W'(1);
                    meta_wdata.fill  = q_fill - FILL_W'(1);
                    qvld_next[q_reg] = 1'b1;
                    pending_next     = pending_reg - PEND_W'(1);
                    res_next.status      = ST_OK;
                    res_next.out_is_send = ~ph_reg;
                    r_next     = r_adv;
                    ph_next    = ph_adv;
                    state_next = S_T_OUT;
                end
                else if (last_pos)
                    state_next = S_DONE;
                else
                begin
                    r_next     = r_adv;
                    ph_next    = ph_adv;
                    n_next     = n_reg + (CNT_W+1)'(1);
                    state_next = S_T_TBL;
                end
            end

            S_T_OUT:
            begin
                res_next.out_task = store_rd;
                if (pending_reg == '0)
                begin
                    cur_round_next = '0;
                    cur_phase_next = 1'b0;
                end
                else
                begin
                    cur_round_next = r_reg;
                    cur_phase_next = ph_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_word_next      = res_reg;
                    rsp_word_next.last = (pending_reg == '0);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rank_count_reg  <= CNT_W'(1);
            group_size_reg  <= CNT_W'(1);
            n_groups_reg    <= CNT_W'(1);
            my_group_reg    <= '0;
            my_local_reg    <= '0;
            table_ready_reg <= 1'b0;
            round_total_reg <= '0;
            pending_reg     <= '0;
            cur_round_reg   <= '0;
            cur_phase_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            qvld_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rank_count_reg  <= rank_count_next;
            group_size_reg  <= group_size_next;
            n_groups_reg    <= n_groups_next;
            my_group_reg    <= my_group_next;
            my_local_reg    <= my_local_next;
            table_ready_reg <= table_ready_next;
            round_total_reg <= round_total_next;
            pending_reg     <= pending_next;
            cur_round_reg   <= cur_round_next;
            cur_phase_reg   <= cur_phase_next;
            rsp_valid_reg   <= rsp_valid_next;
            qvld_reg        <= qvld_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        gs_reg       <= gs_next;
        ng_reg       <= ng_next;
        mg_reg       <= mg_next;
        ml_reg       <= ml_next;
        p2_reg       <= p2_next;
        step_reg     <= step_next;
        gdelta_reg   <= gdelta_next;
        rnd_reg      <= rnd_next;
        d_reg        <= d_next;
        sbase_reg    <= sbase_next;
        rbase_reg    <= rbase_next;
        r_reg        <= r_next;
        ph_reg       <= ph_next;
        n_reg        <= n_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

    // round table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[rnd_reg[RANK_W-1:0]] <= tbl_wdata;
        tbl_rd <= tbl_mem[r_reg];
    end

    // queue head and fill memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        meta_rd     <= meta_mem[meta_raddr];
        meta_vld_rd <= qvld_reg[meta_raddr];
    end

    // task handle memory
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= item_reg.task_id;
        store_rd <= store_mem[store_raddr];
    end

endmodule
